/* hw/rtl/bitmap_slot_range_allocator_macros.svh */
// Assertion macros for the slot range allocator checker.
// Included by the checker file; depends on nothing else.
`ifndef BITMAP_SLOT_RANGE_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_RANGE_ALLOCATOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BSRA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define BSRA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bsra_pkg.sv */
// Shared types and constants for the slot range allocator.
// No dependencies.
package bsra_pkg;

    localparam int WORD_W = 32;

    typedef enum logic {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Index of the lowest set bit of a 32-bit word (word assumed nonzero).
    function automatic logic [4:0] lowest_one(input logic [WORD_W-1:0] w);
        logic [4:0] idx;
        idx = 5'd0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (w[k]) begin
                idx = 5'(k);
            end
        end
        return idx;
    endfunction

    // Number of set bits of a 32-bit word.
    function automatic logic [5:0] ones_count(input logic [WORD_W-1:0] w);
        logic [5:0] c;
        c = 6'd0;
        for (int k = 0; k < WORD_W; k++) begin
            c = c + 6'(w[k]);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/bitmap_slot_range_allocator.sv */
// Slot range allocator on a free bitmap held in a word RAM.
// Depends on bsra_pkg, bsra_map_ram, bsra_clear and bsra_engine.
//
// Usage: the slave channel carries one request per transfer, allocate or
// release. The master channel returns exactly one result per request.
// cfg_* writes the slot_count register; write it only while idle.
// A request visits the 32-bit map rows its range covers, with one RAM read
// state (ST_READ) and one write-back state (ST_SCAN) per row; a request
// that touches no slot visits no row. Each row goes through a
// read/modify/write loop over the map RAM's read and write ports.
// A 1024-slot map has 32 rows.
// Requests are handled one at a time.
// After reset a clearing pass over all SLOTS/32 map rows (rounded up) marks every
// slot free; no request is taken during it, configuration writes are taken.
// The result is held in an output register; while the receiver stalls the
// block can already take the next request and run it; the engine waits
// only when a new result is ready while the previous one is still held.
module bitmap_slot_range_allocator import bsra_pkg::*; #(
    parameter int SLOTS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,     // slot_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // start_slot[9:0], count_or_end[20:10], zero pad
    input  logic        s_tuser,      // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata       // status[0], first[10:1], last[20:11], cleared[31:21]
);

    localparam int ROWS = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IW   = $clog2(SLOTS);

    logic [10:0] slot_count_reg;
    logic        clr_active;
    logic [AW-1:0] clr_addr;
    logic        busy, done, e_wr, st;
    logic [AW-1:0] e_wa, e_ra;
    logic [WORD_W-1:0] e_wd, rd;
    logic        rs;
    logic [9:0]  rf, rl;
    logic [10:0] rc;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        hold;

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= 11'd1024;
        end else if (cfg_valid) begin
            slot_count_reg <= cfg_data;
        end
    end

    bsra_clear #(.ROWS(ROWS), .AW(AW)) u_clear (
        .aclk(aclk), .aresetn(aresetn), .active(clr_active), .addr(clr_addr)
    );

    bsra_map_ram #(.ROWS(ROWS), .AW(AW)) u_ram (
        .aclk(aclk),
        .wr_en(clr_active | e_wr),
        .wr_addr(clr_active ? clr_addr : e_wa),
        .wr_data(clr_active ? '1 : e_wd),
        .rd_addr(e_ra),
        .rd_data(rd)
    );

    // A finished result waits in the engine while the output is still held.
    assign hold     = out_valid_reg && !m_tready;
    assign s_tready = !busy && !clr_active;
    assign st       = s_tvalid && s_tready;

    bsra_engine #(.SLOTS(SLOTS), .IW(IW), .AW(AW), .CW(11)) u_engine (
        .aclk(aclk), .aresetn(aresetn), .slot_count(slot_count_reg),
        .start(st), .stall(hold), .func(s_tuser), .start_slot(s_tdata[9:0]),
        .count_or_end(s_tdata[20:10]), .busy(busy), .done(done),
        .res_status(rs), .res_first(rf), .res_last(rl), .res_cleared(rc),
        .wr_en(e_wr), .wr_addr(e_wa), .wr_data(e_wd), .rd_addr(e_ra), .rd_data(rd)
    );

    // Output register; the engine hands over its result only when the
    // output register is free or draining in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            out_data_reg <= {rc, rl, rf, rs};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hw/rtl/bsra_map_ram.sv */
// Free map storage: one word per row, one read and one write port.
// Uses bsra_pkg for the word width.
module bsra_map_ram import bsra_pkg::*; #(
    parameter int ROWS = 32,
    parameter int AW   = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [ROWS];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/bsra_engine.sv */
// Word-serial scan engine: reads, modifies and writes back map words.
// Uses bsra_pkg and instantiates nothing; drives the map RAM ports.
module bsra_engine import bsra_pkg::*; #(
    parameter int SLOTS = 1024,
    parameter int IW    = 10,
    parameter int AW    = 5,
    parameter int CW    = 11
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [10:0]       slot_count,
    input  logic              start,
    input  logic              stall,
    input  logic              func,
    input  logic [9:0]        start_slot,
    input  logic [10:0]       count_or_end,
    output logic              busy,
    output logic              done,
    output logic              res_status,
    output logic [9:0]        res_first,
    output logic [9:0]        res_last,
    output logic [10:0]       res_cleared,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [WORD_W-1:0] wr_data,
    output logic [AW-1:0]     rd_addr,
    input  logic [WORD_W-1:0] rd_data
);

    // Slot indices are kept wide enough for both the map and the 11-bit fields.
    localparam int NW = (IW + 1 > 11) ? IW + 1 : 11;

    state_t state_reg, state_next;
    logic          func_reg, func_next;
    logic [NW-1:0] lo_reg, lo_next;    // first slot of range of interest
    logic [NW-1:0] hi_reg, hi_next;    // last slot, inclusive
    logic [CW-1:0] want_reg, want_next;
    logic [CW-1:0] seen_reg, seen_next;
    logic          found_reg, found_next;
    logic [NW-1:0] first_reg, first_next;
    logic [NW-1:0] last_reg, last_next;
    logic [AW:0]   row_reg, row_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic          empty_reg, empty_next;

    logic [NW-1:0] row_base, row_top;
    logic [WORD_W-1:0] mask, free_in, taken_in, cand, newword, spanmask;
    logic [NW-1:0] ext_start, ext_end, n_eff, pick;
    logic [5:0]    cand_cnt, rank;
    logic [CW-1:0] remain;
    logic          hit;
    logic [WORD_W-1:0] prefix;

    assign ext_start = NW'(start_slot);
    assign n_eff     = (32'(slot_count) > 32'(SLOTS)) ? NW'(SLOTS) : NW'(slot_count);
    assign ext_end   = (NW'(count_or_end) >= n_eff) ? n_eff - NW'(1) : NW'(count_or_end);

    assign row_base = NW'(row_reg[AW-1:0]) << 5;
    assign row_top  = row_base + NW'(WORD_W - 1);

    // Mask of bits in the current row lying within [lo, hi].
    always_comb begin
        for (int k = 0; k < WORD_W; k++) begin
            mask[k] = ((row_base + NW'(k)) >= lo_reg) && ((row_base + NW'(k)) <= hi_reg);
        end
    end

    assign free_in  = rd_data & mask;
    assign taken_in = ~rd_data & mask;
    assign remain   = want_reg - seen_reg;

    // Allocate: free candidates in this row, and the one that meets the count.
    always_comb begin
        cand     = free_in;
        cand_cnt = ones_count(cand);
        hit      = (CW'(cand_cnt) >= remain);
        prefix   = '0;
        rank     = 6'd0;
        pick     = '0;
        for (int k = 0; k < WORD_W; k++) begin
            if (cand[k]) begin
                rank = rank + 6'd1;
                if (CW'(rank) == remain) begin
                    prefix = WORD_W'(32'hFFFF_FFFF >> (WORD_W - 1 - k));
                end
            end
        end
        if (hit) begin
            cand = cand & prefix;
        end
        for (int k = 0; k < WORD_W; k++) begin
            if (cand[k]) begin
                pick = row_base + NW'(k);
            end
        end
    end

    // Span of this row that becomes taken, from first found slot on.
    always_comb begin
        for (int k = 0; k < WORD_W; k++) begin
            spanmask[k] = mask[k]
                && ((found_reg && ((row_base + NW'(k)) >= first_reg))
                    || (!found_reg && (cand != '0)
                        && ((row_base + NW'(k)) >= (row_base + NW'(lowest_one(cand))))))
                && ((cand == '0) || ((row_base + NW'(k)) <= pick));
        end
        if (func_reg == FUNC_RELEASE) begin
            newword = rd_data | mask;
        end else begin
            newword = rd_data & ~spanmask;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        func_next = func_reg; lo_next = lo_reg; hi_next = hi_reg;
        want_next = want_reg; seen_next = seen_reg; found_next = found_reg;
        first_next = first_reg; last_next = last_reg;
        row_next = row_reg; clr_next = clr_reg; empty_next = empty_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    func_next  = func;
                    lo_next    = ext_start;
                    hi_next    = (func == FUNC_RELEASE) ? ext_end : n_eff - NW'(1);
                    want_next  = (count_or_end == '0) ? CW'(1) : count_or_end;
                    seen_next  = '0;
                    found_next = 1'b0;
                    first_next = '0;
                    last_next  = '0;
                    clr_next   = '0;
                    row_next   = (AW+1)'(start_slot >> 5);
                    empty_next = (n_eff == '0) || (ext_start >= n_eff)
                        || ((func == FUNC_RELEASE) && (ext_end < ext_start));
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = empty_reg ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                if (func_reg == FUNC_RELEASE) begin
                    clr_next = clr_reg + CW'(ones_count(taken_in));
                end else begin
                    if (cand != '0) begin
                        if (!found_reg) begin
                            found_next = 1'b1;
                            first_next = row_base + NW'(lowest_one(cand));
                        end
                        seen_next = seen_reg + CW'(ones_count(cand));
                        last_next = pick;
                    end
                end
                row_next = row_reg + (AW+1)'(1);
                if ((row_top >= hi_reg) || (func_reg == FUNC_ALLOC && cand != '0 && hit)) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_FINISH: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // The result waits here while the output register is still held.
                if (!stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory port and handshake outputs.
    always_comb begin
        rd_addr = row_reg[AW-1:0];
        wr_addr = row_reg[AW-1:0];
        wr_data = newword;
        wr_en   = (state_reg == ST_SCAN);
        busy    = (state_reg != ST_IDLE);
        done    = (state_reg == ST_OUT) && !stall;
        res_status  = (func_reg == FUNC_ALLOC) && !found_reg;
        res_first   = (func_reg == FUNC_ALLOC && found_reg) ? first_reg[9:0] : '0;
        res_last    = (func_reg == FUNC_ALLOC && found_reg) ? last_reg[9:0] : '0;
        res_cleared = (func_reg == FUNC_RELEASE) ? clr_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        func_reg <= func_next; lo_reg <= lo_next; hi_reg <= hi_next;
        want_reg <= want_next; seen_reg <= seen_next; found_reg <= found_next;
        first_reg <= first_next; last_reg <= last_next;
        row_reg <= row_next; clr_reg <= clr_next; empty_reg <= empty_next;
    end

endmodule

/* hw/rtl/bsra_clear.sv */
// Post-reset clearing pass that sets every map word to all free.
// Uses bsra_pkg for the word width.
module bsra_clear import bsra_pkg::*; #(
    parameter int ROWS = 32,
    parameter int AW   = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    output logic          active,
    output logic [AW-1:0] addr
);

    logic [AW:0] cnt_reg, cnt_next;

    // Walk rows once after reset.
    always_comb begin
        cnt_next = (cnt_reg < (AW+1)'(ROWS)) ? cnt_reg + (AW+1)'(1) : cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign active = (cnt_reg < (AW+1)'(ROWS));
    assign addr   = cnt_reg[AW-1:0];

endmodule

/* hw/rtl/bsra_checker.sv */
// Port-level checker for the slot range allocator, bound to the top level.
// Depends on bitmap_slot_range_allocator_macros.svh.
`include "bitmap_slot_range_allocator_macros.svh"
module bsra_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `BSRA_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
    `BSRA_ASSERT_IMPL(a_fail_zero, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[31:1] == 31'd0, "failure carries nonzero fields")
    `BSRA_ASSERT_NEXT(a_one_at_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second request taken while busy")
    `BSRA_ASSERT_IMPL(a_alloc_order, aclk, aresetn, m_tvalid && !m_tdata[0] && m_tdata[31:21] == 11'd0, m_tdata[10:1] <= m_tdata[20:11], "span reversed")

endmodule

bind bitmap_slot_range_allocator bsra_checker u_bsra_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
